[hw/rtl/ei_pkg.sv]
// shared constants and types for the eased interpolation pipeline
`timescale 1ns / 1ps

package ei_pkg;

    // fixed point formats: weights and progress carry FRACTION_BITS fraction bits
    localparam int FRACTION_BITS     = 16;
    localparam int VALUE_BITS        = 32;
    localparam int SINE_TABLE_DEPTH  = 256;
    localparam int MODE_BITS         = 3;

    localparam logic [FRACTION_BITS:0]   WEIGHT_ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS-1:0] WEIGHT_HALF = {1'b1, {(FRACTION_BITS-1){1'b0}}};

    // pi/2 in Q30, used to build the quarter wave table
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_LINEAR   = 3'd0,
        MODE_PINGPONG = 3'd1,
        MODE_QUAD     = 3'd2,
        MODE_SINE     = 3'd3,
        MODE_COSINE   = 3'd4,
        MODE_CUBIC    = 3'd5
    } t_mode;

    typedef logic [FRACTION_BITS:0] t_weight;

endpackage

[hw/rtl/ei_sine_rom.sv]
// quarter wave sine table with registered read
`timescale 1ns / 1ps

module ei_sine_rom
    import ei_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = ei_pkg::SINE_TABLE_DEPTH,
    localparam int IndexBits = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [IndexBits-1:0] i_index,
    output t_weight              o_value
);

    typedef t_weight t_rom [SINE_TABLE_DEPTH + 1];

    // taylor series through x^13, each term truncated to Q30
    function automatic t_weight quarter_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x    = (longint'(k) * HALF_PI_Q30 + longint'(SINE_TABLE_DEPTH / 2))
               / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 156;
        sum  = sum + term;
        sum  = (sum + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
        return sum[FRACTION_BITS:0];
    endfunction

    function automatic t_rom build_table();
        t_rom rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_table();

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_value <= SineRom[i_index];
        end
    end

endmodule

[hw/rtl/easing_interpolator_top.sv]
// eased interpolation between two signed values, six stage pipeline
`timescale 1ns / 1ps
//
// usage
//   input channel: i_valid / o_ready carry one word of mode, start value,
//   end value and progress (unsigned, 1.0 = 2^16, larger values clamp to 1.0)
//   output channel: o_valid / i_ready carry one word with the eased value
//   modes: linear, ping-pong, quadratic ping-pong, raised sine, raised
//   cosine, cubic in-out; codes 6 and 7 act as linear
//   throughput: one word per cycle while i_ready is high; every stage
//   holds a valid bit and loads whenever it is empty or the stage after
//   it moves, so bubbles close up
//   the raised sine and cosine weights read a quarter wave table of
//   SINE_TABLE_DEPTH+1 entries in stage 2; the table is a constant, so
//   there is no fill or clearing pass after reset
//   reset (synchronous, active low) drops every valid bit; data in flight
//   is discarded
//   when the receiver stalls the last stage holds its word, the stages
//   behind it fill up and o_ready falls only once all six are occupied
//
module easing_interpolator_top
    import ei_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = ei_pkg::SINE_TABLE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [MODE_BITS-1:0]         i_mode,
    input  logic signed [VALUE_BITS-1:0] i_start_value,
    input  logic signed [VALUE_BITS-1:0] i_end_value,
    input  logic [FRACTION_BITS:0]       i_progress,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [VALUE_BITS-1:0] o_eased_value
);

    localparam int F          = FRACTION_BITS;
    localparam int NUM_STAGES = 6;
    localparam int FULL_TURN  = 4 * SINE_TABLE_DEPTH;
    // phase holds up to a full turn plus the cosine quarter offset
    localparam int PW         = $clog2(5 * SINE_TABLE_DEPTH + 1);
    localparam int IW         = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int DW         = VALUE_BITS + 1;
    localparam int PRODW      = DW + F + 2;

    // ---------------------------------------------------------------
    // stage handshake: a stage loads when empty or when its successor moves
    // ---------------------------------------------------------------
    logic [NUM_STAGES:1] r_valid;
    logic [NUM_STAGES:1] stage_en;

    always_comb begin
        stage_en[NUM_STAGES] = !r_valid[NUM_STAGES] || i_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[1]) begin
                r_valid[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    assign o_ready = stage_en[1];
    assign o_valid = r_valid[NUM_STAGES];

    // ---------------------------------------------------------------
    // stage 1: clamp progress, fold it at one half, square, sine phase
    // ---------------------------------------------------------------
    t_weight             t_sat;
    logic                after_half;
    logic [F-1:0]        fold;
    logic [2*F-1:0]      fold_sq;
    logic [F+PW:0]       phase_prod;
    logic [F+PW:0]       phase_sum;
    logic [PW-1:0]       phase;
    logic [PW-1:0]       phase_off;
    logic [PW-1:0]       phase_wrap;
    logic [1:0]          quadrant;
    logic [PW-1:0]       quad_base;
    logic [PW-1:0]       phase_rem;
    logic [IW-1:0]       rom_index;

    always_comb begin
        t_sat      = (i_progress > WEIGHT_ONE) ? WEIGHT_ONE : i_progress;
        after_half = t_sat >= (F+1)'(WEIGHT_HALF);
        fold       = after_half ? F'(WEIGHT_ONE - t_sat) : t_sat[F-1:0];
        fold_sq    = fold * fold;

        // p = rnd(t * 4D / ONE), cosine adds a quarter turn, then mod 4D
        phase_prod = (F+PW+1)'(t_sat) * (F+PW+1)'(FULL_TURN);
        phase_sum  = phase_prod + (F+PW+1)'(WEIGHT_HALF);
        phase      = phase_sum[F+PW-1:F];
        phase_off  = phase + ((i_mode == MODE_COSINE) ? PW'(SINE_TABLE_DEPTH) : PW'(0));
        phase_wrap = (phase_off >= PW'(FULL_TURN)) ? phase_off - PW'(FULL_TURN) : phase_off;

        if (phase_wrap >= PW'(3 * SINE_TABLE_DEPTH)) begin
            quadrant  = 2'd3;
            quad_base = PW'(3 * SINE_TABLE_DEPTH);
        end else if (phase_wrap >= PW'(2 * SINE_TABLE_DEPTH)) begin
            quadrant  = 2'd2;
            quad_base = PW'(2 * SINE_TABLE_DEPTH);
        end else if (phase_wrap >= PW'(SINE_TABLE_DEPTH)) begin
            quadrant  = 2'd1;
            quad_base = PW'(SINE_TABLE_DEPTH);
        end else begin
            quadrant  = 2'd0;
            quad_base = '0;
        end
        phase_rem = phase_wrap - quad_base;
        // odd quadrants run the table backwards
        rom_index = quadrant[0] ? IW'(PW'(SINE_TABLE_DEPTH) - phase_rem) : IW'(phase_rem);
    end

    logic [MODE_BITS-1:0]         r_s1_mode;
    logic signed [VALUE_BITS-1:0] r_s1_a;
    logic signed [VALUE_BITS-1:0] r_s1_b;
    t_weight                      r_s1_t;
    logic [F-1:0]                 r_s1_fold;
    logic [2*F-2:0]               r_s1_fold_sq;
    logic [IW-1:0]                r_s1_index;
    logic                         r_s1_neg;
    logic                         r_s1_after_half;

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s1_mode       <= i_mode;
            r_s1_a          <= i_start_value;
            r_s1_b          <= i_end_value;
            r_s1_t          <= t_sat;
            r_s1_fold       <= fold;
            r_s1_fold_sq    <= fold_sq[2*F-2:0];
            r_s1_index      <= rom_index;
            r_s1_neg        <= quadrant[1];
            r_s1_after_half <= after_half;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: table read, quadratic weight, rounded square, span
    // ---------------------------------------------------------------
    t_weight        sine_mag;
    logic [2*F:0]   quad_sum;
    logic [2*F-1:0] sq_sum;

    ei_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_en    (stage_en[2]),
        .i_index (r_s1_index),
        .o_value (sine_mag)
    );

    always_comb begin
        quad_sum = {r_s1_fold_sq, 2'b00} + (2*F+1)'(WEIGHT_HALF);
        sq_sum   = (2*F)'(r_s1_fold_sq) + (2*F)'(WEIGHT_HALF);
    end

    logic [MODE_BITS-1:0]         r_s2_mode;
    logic signed [VALUE_BITS-1:0] r_s2_a;
    logic signed [DW-1:0]         r_s2_d;
    t_weight                      r_s2_t;
    logic [F-1:0]                 r_s2_fold;
    t_weight                      r_s2_quad;
    logic [F-1:0]                 r_s2_sq;
    logic                         r_s2_neg;
    logic                         r_s2_after_half;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s2_mode       <= r_s1_mode;
            r_s2_a          <= r_s1_a;
            r_s2_d          <= DW'(r_s1_b) - DW'(r_s1_a);
            r_s2_t          <= r_s1_t;
            r_s2_fold       <= r_s1_fold;
            r_s2_quad       <= quad_sum[2*F:F];
            r_s2_sq         <= sq_sum[2*F-1:F];
            r_s2_neg        <= r_s1_neg;
            r_s2_after_half <= r_s1_after_half;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: cubic product, raised sine weight, ping-pong weight
    // ---------------------------------------------------------------
    logic [2*F-1:0] cube_prod;
    logic [F+1:0]   sine_sum;

    always_comb begin
        cube_prod = r_s2_sq * r_s2_fold;
        // w = (ONE + s + 1) >> 1 with s = -mag in the lower half turn
        if (r_s2_neg) begin
            sine_sum = (F+2)'(WEIGHT_ONE) - (F+2)'(sine_mag) + (F+2)'(1);
        end else begin
            sine_sum = (F+2)'(WEIGHT_ONE) + (F+2)'(sine_mag) + (F+2)'(1);
        end
    end

    logic [MODE_BITS-1:0]         r_s3_mode;
    logic signed [VALUE_BITS-1:0] r_s3_a;
    logic signed [DW-1:0]         r_s3_d;
    t_weight                      r_s3_t;
    t_weight                      r_s3_ping;
    t_weight                      r_s3_quad;
    t_weight                      r_s3_sine;
    logic [2*F+1:0]               r_s3_cube;
    logic                         r_s3_after_half;

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_s3_mode       <= r_s2_mode;
            r_s3_a          <= r_s2_a;
            r_s3_d          <= r_s2_d;
            r_s3_t          <= r_s2_t;
            r_s3_ping       <= {r_s2_fold, 1'b0};
            r_s3_quad       <= r_s2_quad;
            r_s3_sine       <= sine_sum[F+1:1];
            r_s3_cube       <= {cube_prod, 2'b00};
            r_s3_after_half <= r_s2_after_half;
        end
    end

    // ---------------------------------------------------------------
    // stage 4: round the cube and pick the weight for the mode
    // ---------------------------------------------------------------
    logic [2*F+1:0] cube_sum;
    t_weight        cube_w;
    t_weight        weight;

    always_comb begin
        cube_sum = r_s3_cube + (2*F+2)'(WEIGHT_HALF);
        cube_w   = cube_sum[2*F:F];
        case (t_mode'(r_s3_mode))
            MODE_PINGPONG: weight = r_s3_ping;
            MODE_QUAD:     weight = r_s3_quad;
            MODE_SINE:     weight = r_s3_sine;
            MODE_COSINE:   weight = r_s3_sine;
            MODE_CUBIC:    weight = r_s3_after_half ? WEIGHT_ONE - cube_w : cube_w;
            default:       weight = r_s3_t;
        endcase
    end

    logic signed [VALUE_BITS-1:0] r_s4_a;
    logic signed [DW-1:0]         r_s4_d;
    t_weight                      r_s4_w;

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_s4_a <= r_s3_a;
            r_s4_d <= r_s3_d;
            r_s4_w <= weight;
        end
    end

    // ---------------------------------------------------------------
    // stage 5: span times weight, plus half an lsb for rounding
    // ---------------------------------------------------------------
    logic signed [PRODW-1:0] span_prod;

    always_comb begin
        span_prod = r_s4_d * $signed({1'b0, r_s4_w});
    end

    logic signed [VALUE_BITS-1:0] r_s5_a;
    logic signed [PRODW-1:0]      r_s5_prod;

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_s5_a    <= r_s4_a;
            r_s5_prod <= span_prod + PRODW'(WEIGHT_HALF);
        end
    end

    // ---------------------------------------------------------------
    // stage 6: floor shift and add to the start value, output register
    // ---------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] r_s6_value;

    always_ff @(posedge i_clk) begin
        if (stage_en[6]) begin
            r_s6_value <= r_s5_a + $signed(r_s5_prod[F+VALUE_BITS-1:F]);
        end
    end

    assign o_eased_value = r_s6_value;

`ifndef SYNTHESIS
    // input only backs up once every stage holds a word
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_valid))
        else $error("input stalled while the pipeline has an empty stage");

    // eased weight never exceeds one
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[4] |-> (r_s4_w <= WEIGHT_ONE))
        else $error("eased weight above one");

    // a new output word always comes from the stage before it
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_valid[5]))
        else $error("output valid without a word in the previous stage");
`endif

endmodule
